FILE: rtl/tcsb_pkg.sv
// ============================================================================
// tcsb_pkg: shared types, constants and helpers
// Field layout of the stream words, selector codes and the per-channel
// alpha mix used by the textured column sampler.
// ============================================================================
`default_nettype none

package tcsb_pkg;

   // Storage geometry
   localparam int STORE_DEPTH    = 4096;
   localparam int ADDR_W         = 12;
   localparam int TEXEL_W        = 32;
   localparam int CFG_W          = 7;
   localparam int STEP_FRAC_BITS = 16;
   localparam int STEP_W         = CFG_W + STEP_FRAC_BITS;       // 23
   localparam int ACC_W          = 8 + STEP_FRAC_BITS;           // 24
   localparam int ROW_W          = 13;
   localparam int COORD_W        = 12;
   localparam int WH_W           = 16;
   localparam int COL_W          = 6;
   localparam int RGB_W          = 24;
   localparam int ALPHA_W        = 9;
   localparam int DIV_CNT_W      = 5;

   localparam logic [TEXEL_W-1:0]  TRANSPARENT_TEXEL = 32'hFFFF_FFFF;
   localparam logic [ALPHA_W-1:0]  ALPHA_ONE         = 9'd256;
   localparam logic [ACC_W-1:0]    ACC_MAX           = {ACC_W{1'b1}};
   localparam logic [CFG_W-1:0]    CFG_RESET         = 7'd64;

   // Request tdata layout, lowest bit first
   localparam int REQ_DATA_W   = 136;
   localparam int OFS_INDEX    = 0;
   localparam int OFS_TEXEL    = OFS_INDEX + ADDR_W;       // 12
   localparam int OFS_X        = OFS_TEXEL + TEXEL_W;      // 44
   localparam int OFS_START    = OFS_X + COORD_W;          // 56
   localparam int OFS_END      = OFS_START + COORD_W;      // 68
   localparam int OFS_WH       = OFS_END + COORD_W;        // 80
   localparam int OFS_COL      = OFS_WH + WH_W;            // 96
   localparam int OFS_BLEND    = OFS_COL + COL_W;          // 102
   localparam int OFS_ALPHA    = OFS_BLEND + RGB_W;        // 126

   // Response tdata layout
   localparam int RSP_DATA_W   = 48;

   // Selector codes carried on req_tuser
   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_BEGIN = 2'd1,
      FUNC_ROW   = 2'd2
   } func_type;

   // Register indexes
   localparam logic CSR_TEX_WIDTH  = 1'b0;
   localparam logic CSR_TEX_HEIGHT = 1'b1;

   // (c*(256-a) + b*a) >> 8 on one 8-bit channel
   function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] b,
                                              input logic [ALPHA_W-1:0] a);
      logic [ALPHA_W-1:0] inv;
      logic [16:0]        prod_c;
      logic [16:0]        prod_b;
      logic [16:0]        sum;
      inv    = ALPHA_ONE - a;
      prod_c = {1'b0, c} * {8'b0, inv};
      prod_b = {1'b0, b} * {8'b0, a};
      sum    = prod_c + prod_b;
      return sum[15:8];
   endfunction

   function automatic logic [RGB_W-1:0] mix_rgb(input logic [RGB_W-1:0] c,
                                                input logic [RGB_W-1:0] b,
                                                input logic [ALPHA_W-1:0] a);
      return {mix_channel(c[23:16], b[23:16], a),
              mix_channel(c[15:8],  b[15:8],  a),
              mix_channel(c[7:0],   b[7:0],   a)};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/texture_column_sampler_blend_top.sv
// ============================================================================
// texture_column_sampler_blend_top: textured wall column with alpha blend
// Samples one texture column down a screen strip and mixes a blend colour.
// ============================================================================
// Usage:
//   req_* carries one item per transfer; req_tuser selects the operation:
//   texel write (load one word of the 4096-entry texture memory), begin
//   column (latch the strip and compute step = height / wall height in
//   Q7.16), or next row (sample, blend, emit one pixel on rsp_*).
//   csr_* writes texture width (index 0) and height (index 1), both 64
//   after reset; write them only while no item is in flight.
// Timing:
//   Texel write: written straight into the memory. Begin column: runs the radix-2
//   restoring divider that retires one quotient bit per cycle over 23 bits.
//   Next row: the texel is read into the registered memory output, then
//   blended into the output register once that register is free. A row past
//   the strip end or a transparent texel gives nothing.
// Reset and stall:
//   Reset clears the strip state, the output valid flag and the registers to
//   their defaults; the texture memory is not cleared. When rsp_tready is
//   low with a pixel waiting, a following row item holds in the blend step,
//   with req_tready low, until the output register frees; texel writes and
//   begin column are still taken while no row item holds and no division runs.
// ============================================================================
`default_nettype none

module texture_column_sampler_blend_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // texel_index, texel_data, screen_x, start_row, end_row, wall_height,
   // tex_column, blend_color, alpha, one zero pad bit
   input  wire logic [tcsb_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  wire logic [1:0]                      req_tuser,
   // response channel
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // pixel_x, pixel_y, pixel_color
   output      logic [tcsb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register write port
   input  wire logic                            csr_we,
   input  wire logic                            csr_addr,
   input  wire logic [tcsb_pkg::CFG_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_BLEND
   } state_type;

   // ---------------------------------------------------------------- fields
   tcsb_pkg::func_type                    req_func;
   logic [tcsb_pkg::ADDR_W-1:0]           f_index;
   logic [tcsb_pkg::TEXEL_W-1:0]          f_texel;
   logic [tcsb_pkg::COORD_W-1:0]          f_x;
   logic [tcsb_pkg::COORD_W-1:0]          f_start;
   logic [tcsb_pkg::COORD_W-1:0]          f_end;
   logic [tcsb_pkg::WH_W-1:0]             f_wh;
   logic [tcsb_pkg::COL_W-1:0]            f_col;
   logic [tcsb_pkg::RGB_W-1:0]            f_blend;
   logic [tcsb_pkg::ALPHA_W-1:0]          f_alpha;

   assign req_func = tcsb_pkg::func_type'(req_tuser);
   assign f_index  = req_tdata[tcsb_pkg::OFS_INDEX +: tcsb_pkg::ADDR_W];
   assign f_texel  = req_tdata[tcsb_pkg::OFS_TEXEL +: tcsb_pkg::TEXEL_W];
   assign f_x      = req_tdata[tcsb_pkg::OFS_X     +: tcsb_pkg::COORD_W];
   assign f_start  = req_tdata[tcsb_pkg::OFS_START +: tcsb_pkg::COORD_W];
   assign f_end    = req_tdata[tcsb_pkg::OFS_END   +: tcsb_pkg::COORD_W];
   assign f_wh     = req_tdata[tcsb_pkg::OFS_WH    +: tcsb_pkg::WH_W];
   assign f_col    = req_tdata[tcsb_pkg::OFS_COL   +: tcsb_pkg::COL_W];
   assign f_blend  = req_tdata[tcsb_pkg::OFS_BLEND +: tcsb_pkg::RGB_W];
   assign f_alpha  = req_tdata[tcsb_pkg::OFS_ALPHA +: tcsb_pkg::ALPHA_W];

   // ---------------------------------------------------------------- state
   state_type                             state_ff,      state_in;
   logic [tcsb_pkg::CFG_W-1:0]            tex_width_ff,  tex_width_in;
   logic [tcsb_pkg::CFG_W-1:0]            tex_height_ff, tex_height_in;
   logic [tcsb_pkg::STEP_W-1:0]           step_ff,       step_in;
   logic [tcsb_pkg::ACC_W-1:0]            acc_ff,        acc_in;
   logic [tcsb_pkg::ROW_W-1:0]            row_ff,        row_in;
   logic [tcsb_pkg::COORD_W-1:0]          strip_x_ff,    strip_x_in;
   logic [tcsb_pkg::COORD_W-1:0]          strip_end_ff,  strip_end_in;
   logic [tcsb_pkg::COL_W-1:0]            strip_col_ff,  strip_col_in;
   logic [tcsb_pkg::RGB_W-1:0]            strip_rgb_ff,  strip_rgb_in;
   logic [tcsb_pkg::ALPHA_W-1:0]          strip_a_ff,    strip_a_in;
   // divider
   logic [tcsb_pkg::STEP_W-1:0]           div_q_ff,      div_q_in;
   logic [tcsb_pkg::WH_W-1:0]             div_rem_ff,    div_rem_in;
   logic [tcsb_pkg::WH_W-1:0]             div_den_ff,    div_den_in;
   logic [tcsb_pkg::DIV_CNT_W-1:0]        div_cnt_ff,    div_cnt_in;
   // row pipeline and output register
   logic [tcsb_pkg::COORD_W-1:0]          pend_y_ff,     pend_y_in;
   logic                                  rsp_valid_ff,  rsp_valid_in;
   logic [tcsb_pkg::RSP_DATA_W-1:0]       rsp_data_ff,   rsp_data_in;

   // texture memory, one write or one registered read per cycle
   logic [tcsb_pkg::TEXEL_W-1:0]          tex_mem [tcsb_pkg::STORE_DEPTH];
   logic [tcsb_pkg::TEXEL_W-1:0]          tex_rd_ff;

   // ---------------------------------------------------------------- datapath
   logic                                  accept;
   logic                                  row_past_end;
   logic [7:0]                            acc_row;
   logic [tcsb_pkg::CFG_W-1:0]            trow;
   logic [2*tcsb_pkg::CFG_W-1:0]          addr_full;
   logic [tcsb_pkg::ADDR_W-1:0]           rd_addr;
   logic                                  mem_we;
   logic                                  mem_re;
   logic [tcsb_pkg::ACC_W:0]              acc_sum;
   logic [tcsb_pkg::WH_W:0]               rem_shift;
   logic [tcsb_pkg::WH_W:0]               rem_diff;
   logic                                  rem_ge;
   logic [tcsb_pkg::STEP_W-1:0]           div_q_next;
   logic                                  out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign row_past_end = row_ff > {1'b0, strip_end_ff};

   // Texel row: integer part of the accumulator, clamped to height - 1
   assign acc_row = acc_ff[tcsb_pkg::ACC_W-1:tcsb_pkg::STEP_FRAC_BITS];
   always_comb begin
      if (tex_height_ff == '0) begin
         trow = '0;
      end else if (acc_row >= {1'b0, tex_height_ff}) begin
         trow = tex_height_ff - 7'd1;
      end else begin
         trow = acc_row[tcsb_pkg::CFG_W-1:0];
      end
   end

   // Address wraps modulo the memory depth
   assign addr_full = trow * tex_width_ff + {{(2*tcsb_pkg::CFG_W-tcsb_pkg::COL_W){1'b0}},
                                              strip_col_ff};
   assign rd_addr   = addr_full[tcsb_pkg::ADDR_W-1:0];

   assign mem_we = accept & (req_func == tcsb_pkg::FUNC_WRITE);
   assign mem_re = accept & (req_func == tcsb_pkg::FUNC_ROW) & ~row_past_end;

   // Saturating accumulator advance
   assign acc_sum = {1'b0, acc_ff} + {{(tcsb_pkg::ACC_W-tcsb_pkg::STEP_W+1){1'b0}}, step_ff};

   // One restoring division step: shift in the next dividend bit
   assign rem_shift  = {div_rem_ff, div_q_ff[tcsb_pkg::STEP_W-1]};
   assign rem_ge     = rem_shift >= {1'b0, div_den_ff};
   assign rem_diff   = rem_shift - {1'b0, div_den_ff};
   assign div_q_next = {div_q_ff[tcsb_pkg::STEP_W-2:0], rem_ge};

   always_comb begin
      state_in      = state_ff;
      tex_width_in  = tex_width_ff;
      tex_height_in = tex_height_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      row_in        = row_ff;
      strip_x_in    = strip_x_ff;
      strip_end_in  = strip_end_ff;
      strip_col_in  = strip_col_ff;
      strip_rgb_in  = strip_rgb_ff;
      strip_a_in    = strip_a_ff;
      div_q_in      = div_q_ff;
      div_rem_in    = div_rem_ff;
      div_den_in    = div_den_ff;
      div_cnt_in    = div_cnt_ff;
      pend_y_in     = pend_y_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         case (csr_addr)
            tcsb_pkg::CSR_TEX_WIDTH:  tex_width_in  = csr_wdata;
            tcsb_pkg::CSR_TEX_HEIGHT: tex_height_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  tcsb_pkg::FUNC_BEGIN: begin
                     // latch the strip and start the step division
                     acc_in       = '0;
                     strip_x_in   = f_x;
                     row_in       = {1'b0, f_start};
                     strip_end_in = f_end;
                     strip_col_in = f_col;
                     strip_rgb_in = f_blend;
                     strip_a_in   = (f_alpha > tcsb_pkg::ALPHA_ONE) ? tcsb_pkg::ALPHA_ONE
                                                                    : f_alpha;
                     div_q_in     = {tex_height_ff, {tcsb_pkg::STEP_FRAC_BITS{1'b0}}};
                     div_rem_in   = '0;
                     div_den_in   = (f_wh == '0) ? 16'd1 : f_wh;
                     div_cnt_in   = tcsb_pkg::DIV_CNT_W'(tcsb_pkg::STEP_W);
                     state_in     = ST_DIV;
                  end
                  tcsb_pkg::FUNC_ROW: begin
                     // drop rows past the end, else read and advance
                     if (!row_past_end) begin
                        pend_y_in = row_ff[tcsb_pkg::COORD_W-1:0];
                        row_in    = row_ff + 13'd1;
                        acc_in    = acc_sum[tcsb_pkg::ACC_W] ? tcsb_pkg::ACC_MAX
                                                             : acc_sum[tcsb_pkg::ACC_W-1:0];
                        state_in  = ST_BLEND;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            div_q_in   = div_q_next;
            div_rem_in = rem_ge ? rem_diff[tcsb_pkg::WH_W-1:0]
                                : rem_shift[tcsb_pkg::WH_W-1:0];
            div_cnt_in = div_cnt_ff - 5'd1;
            if (div_cnt_ff == 5'd1) begin
               step_in  = div_q_next;
               state_in = ST_IDLE;
            end
         end
         ST_BLEND: begin
            // hold until the output register frees; skip transparent texels
            if (out_free) begin
               if (tex_rd_ff != tcsb_pkg::TRANSPARENT_TEXEL) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {tcsb_pkg::mix_rgb(tex_rd_ff[31:8], strip_rgb_ff, strip_a_ff),
                                  pend_y_ff, strip_x_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tex_width_ff  <= tcsb_pkg::CFG_RESET;
         tex_height_ff <= tcsb_pkg::CFG_RESET;
         step_ff       <= '0;
         acc_ff        <= '0;
         row_ff        <= '0;
         strip_x_ff    <= '0;
         strip_end_ff  <= '0;
         strip_col_ff  <= '0;
         strip_rgb_ff  <= '0;
         strip_a_ff    <= '0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tex_width_ff  <= tex_width_in;
         tex_height_ff <= tex_height_in;
         step_ff       <= step_in;
         acc_ff        <= acc_in;
         row_ff        <= row_in;
         strip_x_ff    <= strip_x_in;
         strip_end_ff  <= strip_end_in;
         strip_col_ff  <= strip_col_in;
         strip_rgb_ff  <= strip_rgb_in;
         strip_a_ff    <= strip_a_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      div_q_ff    <= div_q_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      pend_y_ff   <= pend_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Texture memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tex_mem[f_index] <= f_texel;
      end
      if (mem_re) begin
         tex_rd_ff <= tex_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // A pixel is only ever produced by the blend step
   a_pixel_from_blend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_BLEND)
      else $error("pixel appeared without a blend step");

   // The division counter runs only during the division
   a_div_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_DIV |-> div_cnt_ff == '0)
      else $error("divider counter active outside division");

   // A row past the strip end leaves the accumulator and row untouched
   a_past_end_frozen: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == tcsb_pkg::FUNC_ROW && row_past_end
      |=> $stable(acc_ff) && $stable(row_ff) && state_ff == ST_IDLE)
      else $error("row past the end changed the strip state");

   // A pending pixel is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLEND && rsp_valid_ff && !rsp_tready |=> state_ff == ST_BLEND)
      else $error("blend step left while the output register was full");

endmodule

`default_nettype wire
